@@ sv/nau_pkg.sv @@
//------------------------------------------------------------------------------
// nau_pkg
// Shared types and constants of the accumulator update engine.
//------------------------------------------------------------------------------
package nau_pkg;

    localparam int LAYER_WIDTH   = 256;
    localparam int FEATURE_COUNT = 768;
    localparam int SLOT_COUNT    = 8;
    localparam int LANES         = 16;
    localparam int COL_W         = $clog2(LAYER_WIDTH);
    localparam int LANE_W        = $clog2(LANES);
    localparam int BEATS         = LAYER_WIDTH / LANES;
    localparam int BEAT_W        = $clog2(BEATS);
    localparam int SLOT_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FEAT_W        = $clog2(FEATURE_COUNT);
    localparam int STORE_WORDS   = FEATURE_COUNT * LAYER_WIDTH;
    localparam int WROW_DEPTH    = FEATURE_COUNT * BEATS;
    localparam int WROW_W        = $clog2(WROW_DEPTH);
    localparam int AROW_DEPTH    = SLOT_COUNT * BEATS;
    localparam int AROW_W        = (AROW_DEPTH > 1) ? $clog2(AROW_DEPTH) : 1;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_UPDATE  = 2'd1,
        REQ_READ    = 2'd2,
        REQ_COMPARE = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  src_slot;
        logic [2:0]  dst_slot;
        logic [1:0]  add_count;
        logic [1:0]  sub_count;
        logic [9:0]  add_feature_a;
        logic [9:0]  add_feature_b;
        logic [9:0]  sub_feature_a;
        logic [9:0]  sub_feature_b;
        logic [17:0] weight_address;
        logic signed [15:0] weight_value;
        logic [7:0]  element_index;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] element_value;
        logic               slots_equal;
    } out_word_t;

    // Classified command handed from the front end to the execution unit.
    typedef struct packed {
        req_t                  op;
        logic [SLOT_W-1:0]     src;
        logic [SLOT_W-1:0]     dst;
        logic [3:0]            row_en;
        logic [3:0][FEAT_W-1:0] rows;
        logic [WROW_W-1:0]     waddr_row;
        logic [LANE_W-1:0]     waddr_lane;
        logic                  wvalid;
        logic [15:0]           wvalue;
        logic [COL_W-1:0]      elem;
        logic                  elem_ok;
    } cmd_t;

endpackage

@@ sv/nnue_accumulator_update.sv @@
//------------------------------------------------------------------------------
// nnue_accumulator_update
// Incremental accumulator engine: weight loads, slot updates, reads, compares.
//
//  channel  | handshake      | word
//  input    | push / full    | nau_pkg::in_word_t  in_word
//  result   | pop / empty    | nau_pkg::out_word_t out_word
//
// An update runs 16 beats of 16 elements through one weight memory port.
// After reset a clearing pass zeroes the slots before any word runs. A waiting
// result holds the execution unit; the four-entry command queue keeps accepting
// until it fills.
//------------------------------------------------------------------------------
module nnue_accumulator_update
(
    input  logic               clk,
    input  logic               rst_n,
    input  nau_pkg::in_word_t  in_word,
    input  logic               push,
    output logic               full,
    output nau_pkg::out_word_t out_word,
    output logic               empty,
    input  logic               pop
);

    nau_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_take;

    nau_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    nau_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .out_word  (out_word),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

@@ sv/nau_front.sv @@
//------------------------------------------------------------------------------
// nau_front
// Accepts request words, classifies them and queues them as commands.
//------------------------------------------------------------------------------
module nau_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  nau_pkg::in_word_t in_word,
    input  logic              push,
    output logic              full,
    output nau_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_take
);

    nau_pkg::cmd_t                     q_mem [nau_pkg::QDEPTH];
    logic [nau_pkg::QPTR_W:0]          wp_reg, wp_next, rp_reg, rp_next;
    nau_pkg::cmd_t                     c;
    logic [1:0]                        na, ns;
    logic                              acc, take;

    assign full      = (wp_reg - rp_reg) == (nau_pkg::QPTR_W+1)'(nau_pkg::QDEPTH);
    assign cmd_valid = wp_reg != rp_reg;
    assign cmd       = q_mem[rp_reg[nau_pkg::QPTR_W-1:0]];
    assign acc       = push && !full;
    assign take      = cmd_take && cmd_valid;
    assign wp_next   = wp_reg + (nau_pkg::QPTR_W+1)'(acc);
    assign rp_next   = rp_reg + (nau_pkg::QPTR_W+1)'(take);

    always_comb
    begin
        na = (in_word.add_count == 2'd3) ? 2'd2 : in_word.add_count;
        ns = (in_word.sub_count == 2'd3) ? 2'd2 : in_word.sub_count;
        c.op  = nau_pkg::req_t'(in_word.req_type);
        c.src = nau_pkg::SLOT_W'(in_word.src_slot % nau_pkg::SLOT_COUNT);
        c.dst = nau_pkg::SLOT_W'(in_word.dst_slot % nau_pkg::SLOT_COUNT);
        c.rows[0] = nau_pkg::FEAT_W'(in_word.add_feature_a);
        c.rows[1] = nau_pkg::FEAT_W'(in_word.add_feature_b);
        c.rows[2] = nau_pkg::FEAT_W'(in_word.sub_feature_a);
        c.rows[3] = nau_pkg::FEAT_W'(in_word.sub_feature_b);
        c.row_en[0] = (na >= 2'd1) && (32'(in_word.add_feature_a) < nau_pkg::FEATURE_COUNT);
        c.row_en[1] = (na == 2'd2) && (32'(in_word.add_feature_b) < nau_pkg::FEATURE_COUNT);
        c.row_en[2] = (ns >= 2'd1) && (32'(in_word.sub_feature_a) < nau_pkg::FEATURE_COUNT);
        c.row_en[3] = (ns == 2'd2) && (32'(in_word.sub_feature_b) < nau_pkg::FEATURE_COUNT);
        c.waddr_row  = nau_pkg::WROW_W'(in_word.weight_address >> nau_pkg::LANE_W);
        c.waddr_lane = nau_pkg::LANE_W'(in_word.weight_address);
        c.wvalid = 32'(in_word.weight_address) < nau_pkg::STORE_WORDS;
        c.wvalue = in_word.weight_value;
        c.elem   = nau_pkg::COL_W'(in_word.element_index);
        c.elem_ok = 32'(in_word.element_index) < nau_pkg::LAYER_WIDTH;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_mem[wp_reg[nau_pkg::QPTR_W-1:0]] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) <= (nau_pkg::QPTR_W+1)'(nau_pkg::QDEPTH))
        else $error("command queue overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cmd_valid) else $error("full queue shows no command");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_valid && !push) |=> !cmd_valid) else $error("command appeared from nothing");

endmodule

@@ sv/nau_back.sv @@
//------------------------------------------------------------------------------
// nau_back
// Executes commands against the weight store and the accumulator slots,
// sixteen elements per beat, and holds the single result register.
//------------------------------------------------------------------------------
module nau_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  nau_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output nau_pkg::out_word_t out_word,
    output logic               empty,
    input  logic               pop
);

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_LOADRD, S_LOADWR, S_UPD, S_READ, S_CMP
    } state_t;

    typedef logic [nau_pkg::LANES-1:0][15:0] row_t;

    row_t wmem [nau_pkg::WROW_DEPTH];
    row_t amem [nau_pkg::AROW_DEPTH];
    row_t bmem [nau_pkg::AROW_DEPTH];

    state_t                      state_reg;
    nau_pkg::cmd_t               c_reg;
    logic [nau_pkg::BEAT_W:0]    beat_reg;
    logic [2:0]                  ph_reg;
    logic [nau_pkg::AROW_W:0]    clr_reg;
    logic                        eq_reg;
    logic                        pend_reg;
    row_t                        wrd_reg, ard_reg, brd_reg, sum_reg;
    row_t                        sum_next;
    logic                        ovalid_reg;
    nau_pkg::out_word_t          out_reg;

    logic [nau_pkg::WROW_W-1:0]  wra;
    logic [nau_pkg::AROW_W-1:0]  ara, bra, awa;
    logic                        awe;
    row_t                        awd;
    logic [nau_pkg::BEAT_W-1:0]  beat;

    function automatic row_t awd_w(row_t r, nau_pkg::cmd_t k);
        row_t t;
        t = r;
        t[k.waddr_lane] = k.wvalue;
        return t;
    endfunction

    assign beat     = c_reg.op == nau_pkg::REQ_READ ?
                      c_reg.elem[nau_pkg::COL_W-1:nau_pkg::LANE_W] :
                      beat_reg[nau_pkg::BEAT_W-1:0];
    assign empty    = !ovalid_reg;
    assign out_word = out_reg;
    assign cmd_take = state_reg == S_IDLE && cmd_valid && !ovalid_reg;

    // Each update beat: read source and four weight rows one per cycle, then write.
    always_comb
    begin
        wra = nau_pkg::WROW_W'(c_reg.waddr_row);
        if (state_reg == S_UPD)
        begin
            wra = nau_pkg::WROW_W'(32'(c_reg.rows[ph_reg[1:0]]) * nau_pkg::BEATS + 32'(beat));
        end
        ara = nau_pkg::AROW_W'(32'(c_reg.src) * nau_pkg::BEATS + 32'(beat));
        bra = nau_pkg::AROW_W'(32'(c_reg.dst) * nau_pkg::BEATS + 32'(beat));
        awa = bra;
        awe = 1'b0;
        awd = sum_reg;
        if (state_reg == S_CLEAR)
        begin
            awa = clr_reg[nau_pkg::AROW_W-1:0];
            awe = 1'b1;
            awd = '0;
        end
        else if (state_reg == S_UPD && ph_reg == 3'd6)
        begin
            awe = 1'b1;
        end
    end

    // Phase 1 starts from the source row; phases 1..4 fold in the enabled weight rows.
    always_comb
    begin
        sum_next = sum_reg;
        if (ph_reg == 3'd1)
        begin
            sum_next = ard_reg;
        end
        for (int l = 0; l < nau_pkg::LANES; l++)
        begin
            if (ph_reg >= 3'd1 && ph_reg <= 3'd4 && c_reg.row_en[ph_reg[1:0] - 2'd1])
            begin
                if (ph_reg <= 3'd2)
                begin
                    sum_next[l] = sum_next[l] + wrd_reg[l];
                end
                else
                begin
                    sum_next[l] = sum_next[l] - wrd_reg[l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wrd_reg <= wmem[wra];
        ard_reg <= amem[ara];
        brd_reg <= bmem[bra];
        if (state_reg == S_LOADWR && c_reg.wvalid)
        begin
            wmem[nau_pkg::WROW_W'(c_reg.waddr_row)] <= awd_w(wrd_reg, c_reg);
        end
        if (awe)
        begin
            amem[awa] <= awd;
            bmem[awa] <= awd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            beat_reg   <= '0;
            ph_reg     <= '0;
            eq_reg     <= 1'b0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            c_reg      <= '0;
            sum_reg    <= '0;
            out_reg    <= '0;
        end
        else
        begin
            if (pop && ovalid_reg)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == nau_pkg::AROW_DEPTH - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        c_reg    <= cmd;
                        beat_reg <= '0;
                        ph_reg   <= '0;
                        eq_reg   <= 1'b1;
                        pend_reg <= 1'b0;
                        case (cmd.op)
                            nau_pkg::REQ_LOAD:    state_reg <= S_LOADRD;
                            nau_pkg::REQ_UPDATE:  state_reg <= S_UPD;
                            nau_pkg::REQ_READ:    state_reg <= S_READ;
                            default:              state_reg <= S_CMP;
                        endcase
                    end
                end
                S_LOADRD: state_reg <= S_LOADWR;
                S_LOADWR: state_reg <= S_IDLE;
                S_UPD:
                begin
                    // Phases 0..3 issue weight reads, 1..4 fold them, 6 writes the beat back.
                    sum_reg <= sum_next;
                    if (ph_reg == 3'd6)
                    begin
                        ph_reg   <= '0;
                        beat_reg <= beat_reg + 1'b1;
                        if (32'(beat_reg) == nau_pkg::BEATS - 1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_READ:
                begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg == 3'd1)
                    begin
                        out_reg <= '{element_value: c_reg.elem_ok ?
                                        brd_reg[c_reg.elem[nau_pkg::LANE_W-1:0]] : 16'sd0,
                                     slots_equal: 1'b0};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_CMP:
                begin
                    beat_reg <= beat_reg + 1'b1;
                    pend_reg <= 1'b1;
                    if (pend_reg && ard_reg != brd_reg)
                    begin
                        eq_reg <= 1'b0;
                    end
                    if (32'(beat_reg) == nau_pkg::BEATS)
                    begin
                        out_reg <= '{element_value: 16'sd0,
                                     slots_equal: eq_reg && ard_reg == brd_reg};
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> !ovalid_reg) else $error("command taken over a waiting result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !cmd_take) else $error("command taken while clearing");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !pop) |=> ovalid_reg) else $error("result dropped");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the accumulator update engine. Weight rows are
// loaded, slots are updated, read and compared with random timing on both
// sides, and each result word is checked against a predictor in the bench.
//------------------------------------------------------------------------------
import nau_pkg::*;

class accum_scoreboard;
    logic [15:0] weights [int];
    logic [15:0] slots [SLOT_COUNT][LAYER_WIDTH];
    out_word_t   pending [$];
    int          mismatches;

    function new();
        mismatches = 0;
        foreach (slots[s, c])
            slots[s][c] = '0;
    endfunction

    function logic [15:0] weight_at(int feature, int column);
        int a;
        a = feature * LAYER_WIDTH + column;
        if (feature >= FEATURE_COUNT || !weights.exists(a))
            return 16'd0;
        return weights[a];
    endfunction

    function void note_input(in_word_t w);
        logic [15:0] row [LAYER_WIDTH];
        logic [15:0] v;
        int nadd;
        int nsub;
        int s;
        int d;
        out_word_t r;
        logic same;
        nadd = (w.add_count > 2'd2) ? 2 : int'(w.add_count);
        nsub = (w.sub_count > 2'd2) ? 2 : int'(w.sub_count);
        s = int'(w.src_slot) % SLOT_COUNT;
        d = int'(w.dst_slot) % SLOT_COUNT;
        r = '0;
        case (req_t'(w.req_type))
            REQ_LOAD:
            begin
                if (int'(w.weight_address) < STORE_WORDS)
                    weights[int'(w.weight_address)] = w.weight_value;
            end
            REQ_UPDATE:
            begin
                for (int c = 0; c < LAYER_WIDTH; c++)
                begin
                    v = slots[s][c];
                    if (nadd >= 1) v = v + weight_at(int'(w.add_feature_a), c);
                    if (nadd >= 2) v = v + weight_at(int'(w.add_feature_b), c);
                    if (nsub >= 1) v = v - weight_at(int'(w.sub_feature_a), c);
                    if (nsub >= 2) v = v - weight_at(int'(w.sub_feature_b), c);
                    row[c] = v;
                end
                for (int c = 0; c < LAYER_WIDTH; c++)
                    slots[d][c] = row[c];
            end
            REQ_READ:
            begin
                if (int'(w.element_index) < LAYER_WIDTH)
                    r.element_value = slots[d][int'(w.element_index)];
                pending.push_back(r);
            end
            default:
            begin
                same = 1'b1;
                for (int c = 0; c < LAYER_WIDTH; c++)
                    if (slots[s][c] != slots[d][c])
                        same = 1'b0;
                r.slots_equal = same;
                pending.push_back(r);
            end
        endcase
    endfunction

    function void check_result(out_word_t got);
        out_word_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result word %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.element_value !== want.element_value || got.slots_equal !== want.slots_equal)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: expected value %0d equal %0b, got value %0d equal %0b",
                         want.element_value, want.slots_equal,
                         got.element_value, got.slots_equal);
        end
    endfunction
endclass

module testbench;
    logic      clk;
    logic      rst_n;
    in_word_t  in_word;
    logic      push;
    logic      full;
    out_word_t out_word;
    logic      empty;
    logic      pop;

    accum_scoreboard board;
    int  idle_cycles;
    bit  quiet;
    bit  stim_done;
    int  loaded_rows [$];

    localparam int WATCHDOG = 20000;

    nnue_accumulator_update dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .push     (push),
        .full     (full),
        .out_word (out_word),
        .empty    (empty),
        .pop      (pop)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_input(in_word);
            if (pop && !empty)
                board.check_result(out_word);
            if ((push && !full) || (pop && !empty) || !rst_n)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 9);
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
        end
    end

    // Leaves push high at the falling edge after the word is taken; the
    // caller drops it once the last word has gone.
    task automatic send(in_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word <= w;
        push    <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_word_t noise_word();
        logic [127:0] raw;
        in_word_t w;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(in_word_t)-1:0];
        return w;
    endfunction

    function automatic int pick_row();
        if (loaded_rows.size() == 0)
            return FEATURE_COUNT + $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0)
            return FEATURE_COUNT + $urandom_range(0, 255);
        return loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
    endfunction

    task automatic load_row(int feature, int mode);
        in_word_t w;
        for (int c = 0; c < LAYER_WIDTH; c++)
        begin
            w = noise_word();
            w.req_type = REQ_LOAD;
            w.weight_address = 18'(feature * LAYER_WIDTH + c);
            case (mode)
                0: w.weight_value = 16'sh7fff;
                1: w.weight_value = 16'sh8000;
                default: w.weight_value = 16'($urandom);
            endcase
            send(w);
        end
        loaded_rows.push_back(feature);
    endtask

    task automatic update(int s, int d, int na, int ns);
        in_word_t w;
        w = noise_word();
        w.req_type = REQ_UPDATE;
        w.src_slot = 3'(s);
        w.dst_slot = 3'(d);
        w.add_count = 2'(na);
        w.sub_count = 2'(ns);
        w.add_feature_a = 10'(pick_row());
        w.add_feature_b = 10'(pick_row());
        w.sub_feature_a = 10'(pick_row());
        w.sub_feature_b = 10'(pick_row());
        send(w);
    endtask

    task automatic read_elem(int d, int e);
        in_word_t w;
        w = noise_word();
        w.req_type = REQ_READ;
        w.dst_slot = 3'(d);
        w.element_index = 8'(e);
        send(w);
    endtask

    task automatic compare(int a, int b);
        in_word_t w;
        w = noise_word();
        w.req_type = REQ_COMPARE;
        w.src_slot = 3'(a);
        w.dst_slot = 3'(b);
        send(w);
    endtask

    initial
    begin
        in_word_t w;
        int wait_cycles;
        board = new();
        rst_n = 1'b0;
        push = 1'b0;
        in_word = '0;
        idle_cycles = 0;
        quiet = 1'b0;
        stim_done = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        load_row(FEATURE_COUNT - 1, 2);
        w = noise_word();
        w.req_type = REQ_LOAD;
        w.weight_address = 18'h3ffff;
        send(w);
        w.weight_address = 18'(STORE_WORDS);
        send(w);
        compare(0, 7);
        read_elem(3, 0);
        update(0, 1, 3, 0);
        read_elem(1, 255);
        update(1, 1, 0, 3);
        update(1, 2, 2, 2);
        update(2, 3, 0, 0);
        compare(2, 3);
        compare(1, 1);
        read_elem(2, 17);
        update(7, 7, 1, 1);
        compare(7, 0);

        for (int i = 0; i < 230; i++)
        begin
            if (i == 190)
                quiet = 1'b1;
            case ($urandom_range(0, 9))
                1, 2, 3: update($urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 3), $urandom_range(0, 3));
                4, 5, 6: read_elem($urandom_range(0, 7), $urandom_range(0, 255));
                7, 8: compare($urandom_range(0, 7), $urandom_range(0, 7));
                default:
                begin
                    w = noise_word();
                    w.req_type = REQ_LOAD;
                    send(w);
                end
            endcase
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
